// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and gated by rst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== design/i2cm_pkg.sv =====
// ---------------------------------------------------------------------------
// i2cm_pkg
// Types and constants shared by the I2C master bit engine modules.
// ---------------------------------------------------------------------------
package i2cm_pkg;

    localparam int HALF_W      = 16;
    localparam int TIMEOUT_W   = 8;
    localparam int BYTE_W      = 8;
    localparam int BITCNT_W    = 4;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [HALF_W-1:0]    HALF_RESET    = 16'd4;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 8'd250;
    localparam logic [BITCNT_W-1:0]  BITS_PER_BYTE = 4'd8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 4'd1;

    // Bus commands
    typedef enum logic [2:0] {
        OP_NONE     = 3'd0,
        OP_INIT     = 3'd1,
        OP_START    = 3'd2,
        OP_STOP     = 3'd3,
        OP_WRITE    = 3'd4,
        OP_READ     = 3'd5,
        OP_WAIT_ACK = 3'd6,
        OP_SEND_ACK = 3'd7
    } op_t;

    // One tick as classified by the front end
    typedef struct packed {
        op_t                op;
        logic               has_cmd;
        logic [BYTE_W-1:0]  tx_byte;
        logic               ack_to_send;
        logic               sda_in;
    } item_t;

    // Queue head as seen by the engine
    typedef struct packed {
        logic  valid;
        item_t item;
    } q_head_t;

endpackage

// ===== design/i2cm_if.sv =====
// ---------------------------------------------------------------------------
// I2C master channel interfaces
// Tick input, result output and configuration write channels.
// ---------------------------------------------------------------------------
interface i2cm_in_if;
    import i2cm_pkg::*;
    logic              valid;
    logic              ready;
    logic [2:0]        opcode;
    logic [BYTE_W-1:0] tx_byte;
    logic              ack_to_send;
    logic              sda_in;

    modport source (output valid, opcode, tx_byte, ack_to_send, sda_in, input ready);
    modport sink   (input valid, opcode, tx_byte, ack_to_send, sda_in, output ready);
endinterface

interface i2cm_out_if;
    import i2cm_pkg::*;
    logic              valid;
    logic              ready;
    logic              scl_level;
    logic              sda_level;
    logic              sda_drive_enable;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] rx_byte;
    logic              ack_seen;

    modport source (output valid, scl_level, sda_level, sda_drive_enable, busy_res,
                    done_res, rx_byte, ack_seen, input ready);
    modport sink   (input valid, scl_level, sda_level, sda_drive_enable, busy_res,
                    done_res, rx_byte, ack_seen, output ready);
endinterface

interface i2cm_cfg_if;
    import i2cm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/i2c_master_bit_engine_top.sv =====
// ---------------------------------------------------------------------------
// i2c_master_bit_engine_top
// I2C master bit engine: tick queue in front, bus sequencer behind it.
// ---------------------------------------------------------------------------
// Each input beat is one sequencer tick and yields exactly one result beat
// with the line levels, busy, done, the last received byte and the last ACK.
// One beat is taken every cycle while the queue has room; the sequencer
// advances one tick per cycle unless the result side stalls, and a result
// appears the cycle after its tick leaves the two-entry input queue. Line
// action holds are counted in ticks, not in clock cycles. Configuration
// writes are taken every cycle; half-period writes apply to the next action.
`include "assert_macros.svh"

module i2c_master_bit_engine_top
    import i2cm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    i2cm_in_if.sink     in_ch,
    i2cm_cfg_if.sink    cfg_ch,
    i2cm_out_if.source  out_ch
);

    q_head_t head;
    logic    pop;

    // Accept and classify ticks
    i2cm_cmd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .head  (head),
        .pop   (pop)
    );

    // Run the bus sequence
    i2cm_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .cfg_ch (cfg_ch),
        .out_ch (out_ch)
    );

    // A full queue means the back end is held by a pending result
    `ASSERT_IMPLIES(a_full_implies_out_pending, !in_ch.ready, out_ch.valid && !$past(out_ch.ready) || out_ch.valid, "queue full with no result pending")
    // The finishing tick leaves the engine idle
    `ASSERT_IMPLIES(a_done_not_busy, out_ch.valid && out_ch.done_res, !out_ch.busy_res, "done reported while busy")
    // The engine only consumes a tick that the queue holds
    `ASSERT_IMPLIES(a_pop_has_item, pop, head.valid, "engine consumed from empty queue")

endmodule

// ===== design/i2cm_cmd_queue.sv =====
// ---------------------------------------------------------------------------
// i2cm_cmd_queue
// Front end: accepts tick beats, decodes the opcode and buffers them in a
// short FIFO so the engine and the input side stall independently.
// ---------------------------------------------------------------------------
module i2cm_cmd_queue
    import i2cm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    i2cm_in_if.sink       in_ch,
    output q_head_t       head,
    input  logic          pop
);

    item_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push;
    logic              do_pop;
    item_t             decoded;

    // Classify the incoming beat
    always_comb
    begin
        decoded.op          = op_t'(in_ch.opcode);
        decoded.has_cmd     = (in_ch.opcode != OP_NONE);
        decoded.tx_byte     = in_ch.tx_byte;
        decoded.ack_to_send = in_ch.ack_to_send;
        decoded.sda_in      = in_ch.sda_in;
    end

    assign in_ch.ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign do_pop      = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.item  = mem[rd_ptr_reg];

    // Store payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= decoded;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== design/i2cm_engine.sv =====
// ---------------------------------------------------------------------------
// i2cm_engine
// Back end: runs the bus sequencer one tick per queued beat, holds the
// configuration registers and presents the line state as the result beat.
// ---------------------------------------------------------------------------
module i2cm_engine
    import i2cm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  q_head_t       head,
    output logic          pop,
    i2cm_cfg_if.sink      cfg_ch,
    i2cm_out_if.source    out_ch
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_INIT_SCL, PH_START_SCL, PH_START_SDA, PH_STOP_SCL, PH_STOP_SDA,
        PH_WR_LOW, PH_WR_DATA, PH_WR_HIGH, PH_WR_TLOW, PH_WR_TSDA, PH_RD_SDA,
        PH_RD_HIGH, PH_RD_LOW, PH_ACK_DRIVE, PH_ACK_LOW, PH_WA_POLL, PH_FINISH
    } phase_t;

    logic [HALF_W-1:0]    half_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;

    phase_t               phase_reg, phase_next;
    logic [BITCNT_W-1:0]  bit_count_reg, bit_count_next;
    logic [BYTE_W-1:0]    shift_reg, shift_next;
    logic [HALF_W-1:0]    hold_reg, hold_next;
    logic [TIMEOUT_W-1:0] wait_reg, wait_next;
    logic                 scl_reg, scl_next;
    logic                 sda_reg, sda_next;
    logic                 oe_reg, oe_next;
    logic                 ack_flag_reg, ack_flag_next;
    logic                 ack_choice_reg, ack_choice_next;
    logic [BYTE_W-1:0]    rx_reg, rx_next;
    logic                 done_reg, done_next;
    logic                 out_valid_reg;

    logic                 go;
    phase_t               go_phase;
    logic [HALF_W-1:0]    hold_load;
    item_t                it;

    assign it  = head.item;
    assign pop = head.valid && (!out_valid_reg || out_ch.ready);

    // A zero half period acts as one tick
    assign hold_load = (half_reg == '0) ? '0 : half_reg - 1'b1;

    // Configuration writes land at once
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg    <= HALF_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                CFG_HALF_PERIOD: half_reg    <= cfg_ch.data;
                CFG_ACK_TIMEOUT: timeout_reg <= cfg_ch.data[TIMEOUT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Sequencer step for one tick
    always_comb
    begin
        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        shift_next      = shift_reg;
        hold_next       = hold_reg;
        wait_next       = wait_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        oe_next         = oe_reg;
        ack_flag_next   = ack_flag_reg;
        ack_choice_next = ack_choice_reg;
        rx_next         = rx_reg;
        done_next       = 1'b0;
        go              = 1'b0;
        go_phase        = phase_reg;

        if (phase_reg == PH_IDLE)
        begin
            if (it.has_cmd)
            begin
                bit_count_next = '0;
                go             = 1'b1;
                case (it.op)
                    OP_INIT:
                    begin
                        oe_next = 1'b1; sda_next = 1'b1; go_phase = PH_INIT_SCL;
                    end
                    OP_START:
                    begin
                        oe_next = 1'b1; sda_next = 1'b1; go_phase = PH_START_SCL;
                    end
                    OP_STOP:
                    begin
                        oe_next = 1'b1; sda_next = 1'b0; go_phase = PH_STOP_SCL;
                    end
                    OP_WRITE:
                    begin
                        shift_next = it.tx_byte;
                        oe_next = 1'b1; scl_next = 1'b0; go_phase = PH_WR_DATA;
                    end
                    OP_READ:
                    begin
                        ack_choice_next = it.ack_to_send;
                        shift_next      = '0;
                        oe_next = 1'b1; scl_next = 1'b0; go_phase = PH_RD_SDA;
                    end
                    OP_WAIT_ACK:
                    begin
                        wait_next = '0;
                        oe_next = 1'b0; scl_next = 1'b1; go_phase = PH_WA_POLL;
                    end
                    OP_SEND_ACK:
                    begin
                        ack_choice_next = it.ack_to_send;
                        oe_next  = 1'b1;
                        sda_next = !it.ack_to_send;
                        scl_next = 1'b1;
                        go_phase = PH_ACK_LOW;
                    end
                    default:
                    begin
                        go = 1'b0;
                    end
                endcase
            end
        end
        else if (hold_reg != '0)
        begin
            hold_next = hold_reg - 1'b1;
        end
        else
        begin
            case (phase_reg)
                PH_INIT_SCL:
                begin
                    scl_next = 1'b1; go = 1'b1; go_phase = PH_FINISH;
                end
                PH_START_SCL:
                begin
                    scl_next = 1'b1; go = 1'b1; go_phase = PH_START_SDA;
                end
                PH_START_SDA:
                begin
                    sda_next = 1'b0; go = 1'b1; go_phase = PH_FINISH;
                end
                PH_STOP_SCL:
                begin
                    scl_next = 1'b1; go = 1'b1; go_phase = PH_STOP_SDA;
                end
                PH_STOP_SDA:
                begin
                    sda_next = 1'b1; go = 1'b1; go_phase = PH_FINISH;
                end
                PH_WR_LOW:
                begin
                    scl_next = 1'b0; go = 1'b1; go_phase = PH_WR_DATA;
                end
                PH_WR_DATA:
                begin
                    sda_next = shift_reg[BYTE_W-1]; go = 1'b1; go_phase = PH_WR_HIGH;
                end
                PH_WR_HIGH:
                begin
                    scl_next       = 1'b1;
                    shift_next     = {shift_reg[BYTE_W-2:0], 1'b0};
                    bit_count_next = bit_count_reg + 1'b1;
                    go             = 1'b1;
                    go_phase       = (bit_count_next >= BITS_PER_BYTE) ? PH_WR_TLOW : PH_WR_LOW;
                end
                PH_WR_TLOW:
                begin
                    scl_next = 1'b0; go = 1'b1; go_phase = PH_WR_TSDA;
                end
                PH_WR_TSDA:
                begin
                    sda_next = 1'b1; go = 1'b1; go_phase = PH_FINISH;
                end
                PH_RD_SDA:
                begin
                    sda_next = 1'b1; go = 1'b1; go_phase = PH_RD_HIGH;
                end
                PH_RD_HIGH:
                begin
                    oe_next = 1'b0; scl_next = 1'b1; go = 1'b1; go_phase = PH_RD_LOW;
                end
                PH_RD_LOW:
                begin
                    shift_next     = {shift_reg[BYTE_W-2:0], it.sda_in};
                    scl_next       = 1'b0;
                    bit_count_next = bit_count_reg + 1'b1;
                    go             = 1'b1;
                    go_phase       = (bit_count_next >= BITS_PER_BYTE) ? PH_ACK_DRIVE
                                                                       : PH_RD_HIGH;
                end
                PH_ACK_DRIVE:
                begin
                    rx_next  = shift_reg;
                    oe_next  = 1'b1;
                    sda_next = !ack_choice_reg;
                    scl_next = 1'b1;
                    go       = 1'b1;
                    go_phase = PH_ACK_LOW;
                end
                PH_ACK_LOW:
                begin
                    scl_next = 1'b0; go = 1'b1; go_phase = PH_FINISH;
                end
                PH_WA_POLL:
                begin
                    // Release SCL early when the slave acknowledges or time runs out
                    if (!it.sda_in)
                    begin
                        ack_flag_next = 1'b1; scl_next = 1'b0; go = 1'b1; go_phase = PH_FINISH;
                    end
                    else if (wait_reg >= timeout_reg)
                    begin
                        ack_flag_next = 1'b0; scl_next = 1'b0; go = 1'b1; go_phase = PH_FINISH;
                    end
                    else
                    begin
                        wait_next = wait_reg + 1'b1;
                    end
                end
                PH_FINISH:
                begin
                    phase_next     = PH_IDLE;
                    bit_count_next = '0;
                    done_next      = 1'b1;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        if (go)
        begin
            hold_next  = hold_load;
            phase_next = go_phase;
        end
    end

    // Hold sequencer state; the state itself is the result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_count_reg  <= '0;
            shift_reg      <= '0;
            hold_reg       <= '0;
            wait_reg       <= '0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            oe_reg         <= 1'b1;
            ack_flag_reg   <= 1'b0;
            ack_choice_reg <= 1'b0;
            rx_reg         <= '0;
            done_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg      <= phase_next;
                bit_count_reg  <= bit_count_next;
                shift_reg      <= shift_next;
                hold_reg       <= hold_next;
                wait_reg       <= wait_next;
                scl_reg        <= scl_next;
                sda_reg        <= sda_next;
                oe_reg         <= oe_next;
                ack_flag_reg   <= ack_flag_next;
                ack_choice_reg <= ack_choice_next;
                rx_reg         <= rx_next;
                done_reg       <= done_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.scl_level        = scl_reg;
    assign out_ch.sda_level        = sda_reg;
    assign out_ch.sda_drive_enable = oe_reg;
    assign out_ch.busy_res         = (phase_reg != PH_IDLE);
    assign out_ch.done_res         = done_reg;
    assign out_ch.rx_byte          = rx_reg;
    assign out_ch.ack_seen         = ack_flag_reg;

endmodule

// ===== tb/sv/tb_i2c_master_bit_engine_top.sv =====
// ----------------------------------------------------------------------------
// I2C master bit engine testbench
// Drives bus ticks into the engine and checks every result beat against a
// tick-accurate model of the line sequencer. A short table of commands and
// register writes comes first, then random bus transfers with a simulated
// slave that answers reads and ACK polls. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_i2c_master_bit_engine_top;
    import i2cm_pkg::*;

    localparam int LIMIT_CYCLES = 3000000;

    // Sequencer steps, one per line action
    typedef enum logic [4:0] {
        S_IDLE, S_INIT_SCL, S_START_SCL, S_START_SDA, S_STOP_SCL, S_STOP_SDA,
        S_WR_LOW, S_WR_DATA, S_WR_HIGH, S_WR_TLOW, S_WR_TSDA, S_RD_SDA,
        S_RD_HIGH, S_RD_LOW, S_ACK_DRIVE, S_ACK_LOW, S_WA_POLL, S_FINISH
    } seq_state_t;

    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] tx;
        logic              ack;
        logic              sda;
    } tick_t;

    typedef struct packed {
        logic              scl;
        logic              sda;
        logic              oe;
        logic              busy;
        logic              done;
        logic [BYTE_W-1:0] rx;
        logic              ack;
    } bus_result_t;

    typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        op_t                   op;
        logic [BYTE_W-1:0]     tx;
        logic                  ack;
        int                    resp;   // read: slave byte; wait ack: delay, -1 never
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        bit                    typed;
        bus_result_t           texp;
    } dir_row_t;

    localparam bus_result_t NO_EXP = '0;

    logic clk;
    logic rst_n;

    i2cm_in_if  in_ch();
    i2cm_cfg_if cfg_ch();
    i2cm_out_if out_ch();

    i2c_master_bit_engine_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .cfg_ch (cfg_ch),
        .out_ch (out_ch)
    );

    // Line sequencer model state
    seq_state_t         m_state;
    logic [BITCNT_W-1:0] m_bits;
    logic [BYTE_W-1:0]  m_shift;
    logic [HALF_W-1:0]  m_hold;
    logic [TIMEOUT_W-1:0] m_wait;
    logic               m_scl;
    logic               m_sda;
    logic               m_oe;
    logic               m_ack;
    logic               m_ackc;
    logic [BYTE_W-1:0]  m_rx;
    logic [HALF_W-1:0]  m_half;
    logic [TIMEOUT_W-1:0] m_tmo;

    // Slave responder state
    int                 ack_wait;
    logic [BYTE_W-1:0]  rd_data;

    bus_result_t        line_expect_q[$];
    tick_t              xfer_plan_q[$];
    dir_row_t           dir_tab[$];

    bit  gaps_on;
    bit  rx_stall_on;
    int  burst_left;
    bit  long_stall_req;
    int  long_stall_len;

    int  errors;
    int  beats_checked;
    int  ticks_sent;
    int  cmds_issued;
    int  cfg_writes;
    int  acks_seen;
    int  ack_timeouts;
    longint cycle_cnt;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Abort a hung run
    initial cycle_cnt = 0;
    always @(posedge clk)
    begin
        cycle_cnt = cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES)
        begin
            $display("%0t: cycle limit reached, %0d results still pending",
                     $time, line_expect_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer model
    // ------------------------------------------------------------------------
    function automatic void model_reset();
        m_state = S_IDLE;
        m_bits  = '0;
        m_shift = '0;
        m_hold  = '0;
        m_wait  = '0;
        m_scl   = 1'b1;
        m_sda   = 1'b1;
        m_oe    = 1'b1;
        m_ack   = 1'b0;
        m_ackc  = 1'b0;
        m_rx    = '0;
        m_half  = HALF_RESET;
        m_tmo   = TIMEOUT_RESET;
    endfunction

    // Move to the next step and hold the lines for one half period
    function automatic void enter(seq_state_t nxt);
        m_hold  = (m_half == '0) ? '0 : m_half - 1'b1;
        m_state = nxt;
    endfunction

    function automatic bus_result_t advance_engine(tick_t t);
        bus_result_t r;
        logic        done;
        done = 1'b0;
        if (m_state == S_IDLE)
        begin
            if (t.op != OP_NONE)
            begin
                m_bits = '0;
                case (t.op)
                    OP_INIT:
                    begin
                        m_oe = 1'b1; m_sda = 1'b1; enter(S_INIT_SCL);
                    end
                    OP_START:
                    begin
                        m_oe = 1'b1; m_sda = 1'b1; enter(S_START_SCL);
                    end
                    OP_STOP:
                    begin
                        m_oe = 1'b1; m_sda = 1'b0; enter(S_STOP_SCL);
                    end
                    OP_WRITE:
                    begin
                        m_shift = t.tx; m_oe = 1'b1; m_scl = 1'b0; enter(S_WR_DATA);
                    end
                    OP_READ:
                    begin
                        m_ackc = t.ack; m_shift = '0; m_oe = 1'b1; m_scl = 1'b0;
                        enter(S_RD_SDA);
                    end
                    OP_WAIT_ACK:
                    begin
                        m_wait = '0; m_oe = 1'b0; m_scl = 1'b1; enter(S_WA_POLL);
                    end
                    OP_SEND_ACK:
                    begin
                        m_ackc = t.ack; m_oe = 1'b1; m_sda = !t.ack; m_scl = 1'b1;
                        enter(S_ACK_LOW);
                    end
                    default: ;
                endcase
            end
        end
        else if (m_hold != '0)
        begin
            m_hold = m_hold - 1'b1;
        end
        else
        begin
            case (m_state)
                S_INIT_SCL:  begin m_scl = 1'b1; enter(S_FINISH); end
                S_START_SCL: begin m_scl = 1'b1; enter(S_START_SDA); end
                S_START_SDA: begin m_sda = 1'b0; enter(S_FINISH); end
                S_STOP_SCL:  begin m_scl = 1'b1; enter(S_STOP_SDA); end
                S_STOP_SDA:  begin m_sda = 1'b1; enter(S_FINISH); end
                S_WR_LOW:    begin m_scl = 1'b0; enter(S_WR_DATA); end
                S_WR_DATA:   begin m_sda = m_shift[7]; enter(S_WR_HIGH); end
                S_WR_HIGH:
                begin
                    m_scl   = 1'b1;
                    m_shift = {m_shift[6:0], 1'b0};
                    m_bits  = m_bits + 1'b1;
                    if (m_bits >= BITS_PER_BYTE)
                        enter(S_WR_TLOW);
                    else
                        enter(S_WR_LOW);
                end
                S_WR_TLOW:   begin m_scl = 1'b0; enter(S_WR_TSDA); end
                S_WR_TSDA:   begin m_sda = 1'b1; enter(S_FINISH); end
                S_RD_SDA:    begin m_sda = 1'b1; enter(S_RD_HIGH); end
                S_RD_HIGH:   begin m_oe = 1'b0; m_scl = 1'b1; enter(S_RD_LOW); end
                S_RD_LOW:
                begin
                    m_shift = {m_shift[6:0], t.sda};
                    m_scl   = 1'b0;
                    m_bits  = m_bits + 1'b1;
                    if (m_bits >= BITS_PER_BYTE)
                        enter(S_ACK_DRIVE);
                    else
                        enter(S_RD_HIGH);
                end
                S_ACK_DRIVE:
                begin
                    m_rx = m_shift; m_oe = 1'b1; m_sda = !m_ackc; m_scl = 1'b1;
                    enter(S_ACK_LOW);
                end
                S_ACK_LOW:   begin m_scl = 1'b0; enter(S_FINISH); end
                S_WA_POLL:
                begin
                    if (t.sda == 1'b0)
                    begin
                        m_ack = 1'b1; m_scl = 1'b0; enter(S_FINISH);
                        acks_seen++;
                    end
                    else if (m_wait >= m_tmo)
                    begin
                        m_ack = 1'b0; m_scl = 1'b0; enter(S_FINISH);
                        ack_timeouts++;
                    end
                    else
                    begin
                        m_wait = m_wait + 1'b1;
                    end
                end
                S_FINISH:
                begin
                    m_state = S_IDLE; m_bits = '0; done = 1'b1;
                end
                default: m_state = S_IDLE;
            endcase
        end
        r.scl  = m_scl;
        r.sda  = m_sda;
        r.oe   = m_oe;
        r.busy = (m_state != S_IDLE);
        r.done = done;
        r.rx   = m_rx;
        r.ack  = m_ack;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Slave side: answer ACK polls after a delay, shift out the read byte
    // ------------------------------------------------------------------------
    function automatic logic slave_sda();
        if (m_state == S_WA_POLL && m_hold == '0)
        begin
            if (ack_wait == 0)
                return 1'b0;
            if (ack_wait > 0)
                ack_wait--;
            return 1'b1;
        end
        if (m_state == S_RD_LOW && m_hold == '0)
            return rd_data[7 - int'(m_bits)];
        return 1'($urandom_range(0, 1));
    endfunction

    // Tick while a command runs: any opcode, which the engine must ignore
    function automatic tick_t busy_tick();
        tick_t t;
        t.op  = op_t'($urandom_range(0, 7));
        t.tx  = 8'($urandom_range(0, 255));
        t.ack = 1'($urandom_range(0, 1));
        t.sda = slave_sda();
        return t;
    endfunction

    function automatic tick_t rand_cmd(op_t op);
        tick_t t;
        t.op  = op;
        t.tx  = 8'($urandom_range(0, 255));
        t.ack = 1'($urandom_range(0, 1));
        t.sda = 1'($urandom_range(0, 1));
        return t;
    endfunction

    // Queue one bus transfer (start, address, data bytes, stop) or a lone command
    function automatic void plan_transfer();
        int   n;
        logic rw;
        tick_t t;
        if ($urandom_range(0, 6) == 0)
        begin
            xfer_plan_q.push_back(rand_cmd(op_t'($urandom_range(1, 7))));
            return;
        end
        if ($urandom_range(0, 5) == 0)
            xfer_plan_q.push_back(rand_cmd(OP_INIT));
        xfer_plan_q.push_back(rand_cmd(OP_START));
        t  = rand_cmd(OP_WRITE);
        rw = t.tx[0];
        xfer_plan_q.push_back(t);
        xfer_plan_q.push_back(rand_cmd(OP_WAIT_ACK));
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
        begin
            if (rw)
            begin
                t     = rand_cmd(OP_READ);
                t.ack = (i != n - 1);
                xfer_plan_q.push_back(t);
            end
            else
            begin
                xfer_plan_q.push_back(rand_cmd(OP_WRITE));
                xfer_plan_q.push_back(rand_cmd(OP_WAIT_ACK));
            end
        end
        if ($urandom_range(0, 4) == 0)
            xfer_plan_q.push_back(rand_cmd(OP_SEND_ACK));
        xfer_plan_q.push_back(rand_cmd(OP_STOP));
        // Break off some transfers early
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) void'(xfer_plan_q.pop_back());
    endfunction

    // ------------------------------------------------------------------------
    // Input driver: one tick per beat, bursts with random gaps
    // ------------------------------------------------------------------------
    task automatic send_tick(tick_t t, bit typed, bus_result_t texp);
        bus_result_t r;
        int          gap;
        @(negedge clk);
        if (gaps_on && burst_left == 0)
        begin
            gap        = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 40);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.opcode      <= t.op;
        in_ch.tx_byte     <= t.tx;
        in_ch.ack_to_send <= t.ack;
        in_ch.sda_in      <= t.sda;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        if (m_state == S_IDLE && t.op != OP_NONE)
            cmds_issued++;
        r = advance_engine(t);
        line_expect_q.push_back(typed ? texp : r);
        ticks_sent++;
    endtask

    // Drop valid and wait until every result beat has come back
    task automatic wait_drained();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (line_expect_q.size() != 0) @(posedge clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        if (idx == CFG_HALF_PERIOD)
            m_half = val;
        else if (idx == CFG_ACK_TIMEOUT)
            m_tmo = val[TIMEOUT_W-1:0];
        cfg_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Issue one command and feed ticks until the engine is idle again
    task automatic run_command(dir_row_t row);
        tick_t t;
        if (row.op == OP_READ)
            rd_data = row.resp[7:0];
        if (row.op == OP_WAIT_ACK)
            ack_wait = row.resp;
        t.op  = row.op;
        t.tx  = row.tx;
        t.ack = row.ack;
        t.sda = 1'($urandom_range(0, 1));
        send_tick(t, row.typed, row.texp);
        while (m_state != S_IDLE)
            send_tick(busy_tick(), 1'b0, NO_EXP);
    endtask

    // Random transfers under one register setting, about nticks ticks long
    task automatic run_random(logic [HALF_W-1:0] half, logic [TIMEOUT_W-1:0] tmo,
                              int nticks, bit gaps, bit stalls, bit squeeze);
        int    first_tick;
        tick_t t;
        wait_drained();
        write_cfg(CFG_HALF_PERIOD, half);
        write_cfg(CFG_ACK_TIMEOUT, CFG_DATA_W'(tmo));
        gaps_on     = gaps;
        rx_stall_on = stalls;
        first_tick  = ticks_sent;
        // Run past the budget until the current command has finished
        while (ticks_sent - first_tick < nticks || m_state != S_IDLE)
        begin
            if (squeeze && ticks_sent - first_tick >= 20)
            begin
                long_stall_len = 400;
                long_stall_req = !long_stall_req;
                squeeze        = 1'b0;
            end
            if (m_state == S_IDLE)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    t = rand_cmd(OP_NONE);
                end
                else
                begin
                    if (xfer_plan_q.size() == 0)
                        plan_transfer();
                    t = xfer_plan_q.pop_front();
                    if (t.op == OP_READ)
                        rd_data = 8'($urandom_range(0, 255));
                    if (t.op == OP_WAIT_ACK)
                    begin
                        if ($urandom_range(0, 3) == 0)
                            ack_wait = -1;
                        else if ($urandom_range(0, 1) == 0)
                            ack_wait = $urandom_range(0, 3);
                        else
                            ack_wait = $urandom_range(0, int'(m_tmo) + 1);
                    end
                end
            end
            else
            begin
                t = busy_tick();
            end
            send_tick(t, 1'b0, NO_EXP);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result receiver: stall pattern plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin
        int hold_left;
        bit seen_req;
        int rx_cyc;
        hold_left    = 0;
        seen_req     = 1'b0;
        rx_cyc       = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_stall_req != seen_req)
            begin
                seen_req  = long_stall_req;
                hold_left = long_stall_len;
            end
            rx_cyc++;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (!rx_stall_on)
                out_ch.ready <= 1'b1;
            else
                out_ch.ready <= !((rx_cyc % 13) < 3 || $urandom_range(0, 9) == 0);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    task automatic check_field(string fname, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h",
                     $time, fname, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        bus_result_t got;
        bus_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.scl  = out_ch.scl_level;
            got.sda  = out_ch.sda_level;
            got.oe   = out_ch.sda_drive_enable;
            got.busy = out_ch.busy_res;
            got.done = out_ch.done_res;
            got.rx   = out_ch.rx_byte;
            got.ack  = out_ch.ack_seen;
            if (line_expect_q.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with none expected, expected none, got %0h",
                         $time, got);
            end
            else
            begin
                want = line_expect_q.pop_front();
                beats_checked++;
                check_field("scl_level", 8'(want.scl), 8'(got.scl));
                check_field("sda_level", 8'(want.sda), 8'(got.sda));
                check_field("sda_drive_enable", 8'(want.oe), 8'(got.oe));
                check_field("busy_res", 8'(want.busy), 8'(got.busy));
                check_field("done_res", 8'(want.done), 8'(got.done));
                check_field("rx_byte", want.rx, got.rx);
                check_field("ack_seen", 8'(want.ack), 8'(got.ack));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------------
    function automatic void cmd_row(op_t op, logic [7:0] tx, logic ack, int resp,
                                    bit typed, bus_result_t texp);
        dir_row_t row;
        row.kind  = ROW_CMD;
        row.op    = op;
        row.tx    = tx;
        row.ack   = ack;
        row.resp  = resp;
        row.idx   = '0;
        row.data  = '0;
        row.typed = typed;
        row.texp  = texp;
        dir_tab.push_back(row);
    endfunction

    function automatic void cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        dir_row_t row;
        row.kind  = ROW_CFG;
        row.op    = OP_NONE;
        row.tx    = '0;
        row.ack   = 1'b0;
        row.resp  = 0;
        row.idx   = idx;
        row.data  = data;
        row.typed = 1'b0;
        row.texp  = NO_EXP;
        dir_tab.push_back(row);
    endfunction

    function automatic void build_table();
        // Idle after reset, then the first tick of init
        cmd_row(OP_NONE, 8'h00, 1'b0, 0, 1'b1,
                '{scl:1'b1, sda:1'b1, oe:1'b1, busy:1'b0, done:1'b0, rx:8'h00, ack:1'b0});
        cmd_row(OP_INIT, 8'hFF, 1'b1, 0, 1'b1,
                '{scl:1'b1, sda:1'b1, oe:1'b1, busy:1'b1, done:1'b0, rx:8'h00, ack:1'b0});
        // Short sequences at the reset half period
        cmd_row(OP_START,    8'h00, 1'b0, 0,     1'b0, NO_EXP);
        cmd_row(OP_WAIT_ACK, 8'h00, 1'b0, 2,     1'b0, NO_EXP);
        cmd_row(OP_SEND_ACK, 8'h00, 1'b1, 0,     1'b0, NO_EXP);
        cmd_row(OP_STOP,     8'h00, 1'b0, 0,     1'b0, NO_EXP);
        // Byte transfers with one-tick holds and a short ACK window
        cfg_row(CFG_HALF_PERIOD, 16'h0001);
        cfg_row(CFG_ACK_TIMEOUT, 16'h0006);
        cmd_row(OP_START,    8'h00, 1'b0, 0,     1'b0, NO_EXP);
        cmd_row(OP_WRITE,    8'hFF, 1'b0, 0,     1'b0, NO_EXP);
        cmd_row(OP_WAIT_ACK, 8'h00, 1'b0, 0,     1'b0, NO_EXP);
        cmd_row(OP_WRITE,    8'h00, 1'b1, 0,     1'b0, NO_EXP);
        cmd_row(OP_WAIT_ACK, 8'hFF, 1'b1, -1,    1'b0, NO_EXP);
        cmd_row(OP_WRITE,    8'hA5, 1'b0, 0,     1'b0, NO_EXP);
        cmd_row(OP_WAIT_ACK, 8'h00, 1'b0, 5,     1'b0, NO_EXP);
        cmd_row(OP_READ,     8'h00, 1'b1, 8'hFF, 1'b0, NO_EXP);
        cmd_row(OP_READ,     8'hFF, 1'b0, 8'h00, 1'b0, NO_EXP);
        cmd_row(OP_READ,     8'h00, 1'b1, 8'h5A, 1'b0, NO_EXP);
        cmd_row(OP_SEND_ACK, 8'h00, 1'b1, 0,     1'b0, NO_EXP);
        cmd_row(OP_SEND_ACK, 8'hFF, 1'b0, 0,     1'b0, NO_EXP);
        cmd_row(OP_STOP,     8'h00, 1'b0, 0,     1'b0, NO_EXP);
        // Indexes past the register list must change nothing
        cfg_row(4'd2, 16'hFFFF);
        cfg_row(4'd15, 16'h0001);
        // Zero half period acts as one tick; zero timeout polls once
        cfg_row(CFG_HALF_PERIOD, 16'h0000);
        cfg_row(CFG_ACK_TIMEOUT, 16'h0000);
        cmd_row(OP_START,    8'h00, 1'b0, 0,  1'b0, NO_EXP);
        cmd_row(OP_WRITE,    8'h81, 1'b0, 0,  1'b0, NO_EXP);
        cmd_row(OP_WAIT_ACK, 8'h00, 1'b0, -1, 1'b0, NO_EXP);
        cmd_row(OP_WAIT_ACK, 8'h00, 1'b0, 0,  1'b0, NO_EXP);
        cmd_row(OP_STOP,     8'h00, 1'b0, 0,  1'b0, NO_EXP);
        // Longest timeout runs out the full poll window
        cfg_row(CFG_ACK_TIMEOUT, 16'h00FF);
        cmd_row(OP_WAIT_ACK, 8'h00, 1'b0, -1, 1'b0, NO_EXP);
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.opcode      = OP_NONE;
        in_ch.tx_byte     = '0;
        in_ch.ack_to_send = 1'b0;
        in_ch.sda_in      = 1'b1;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        gaps_on           = 1'b1;
        rx_stall_on       = 1'b1;
        burst_left        = 0;
        long_stall_req    = 1'b0;
        long_stall_len    = 0;
        ack_wait          = -1;
        rd_data           = '0;
        errors            = 0;
        beats_checked     = 0;
        ticks_sent        = 0;
        cmds_issued       = 0;
        cfg_writes        = 0;
        acks_seen         = 0;
        ack_timeouts      = 0;
        model_reset();
        build_table();

        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed table
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_CFG)
            begin
                wait_drained();
                write_cfg(dir_tab[i].idx, dir_tab[i].data);
            end
            else
                run_command(dir_tab[i]);
        end

        // Random transfers over several register settings
        run_random(16'd1, 8'd0,   80, 1'b1, 1'b1, 1'b1);
        run_random(16'd2, 8'd12,  70, 1'b1, 1'b1, 1'b0);
        run_random(16'd0, 8'd3,   60, 1'b0, 1'b0, 1'b0);
        run_random(16'd3, 8'($urandom_range(0, 15)), 60, 1'b1, 1'b1, 1'b0);
        run_random(16'($urandom_range(1, 3)), 8'($urandom_range(0, 10)),
                   60, 1'b1, 1'b0, 1'b0);

        // Let the tail drain and watch for stray beats
        wait_drained();
        repeat (8) @(posedge clk);

        $display("Ran %0d ticks with %0d commands and %0d register writes.",
                 ticks_sent, cmds_issued, cfg_writes);
        $display("Checked %0d result beats; %0d ACKs seen, %0d ACK timeouts.",
                 beats_checked, acks_seen, ack_timeouts);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== i2c_master_bit_engine_top.f =====
+incdir+design
design/i2cm_pkg.sv
design/i2cm_if.sv
design/i2cm_cmd_queue.sv
design/i2cm_engine.sv
design/i2c_master_bit_engine_top.sv
tb/sv/tb_i2c_master_bit_engine_top.sv
